/* src/pcw_pkg.sv */
// ----------------------------------------------------------------------------
// pcw_pkg
// types and constants shared by the periodic cell wrap block
// ----------------------------------------------------------------------------
package pcw_pkg;

  localparam int MaxShifts  = 15;
  localparam int CoordBits  = 20;
  localparam int SlotBits   = 20;
  localparam int SatBits    = (CoordBits < SlotBits) ? CoordBits : SlotBits;
  localparam int NormBits   = 41;
  localparam int DiffBits   = 22;
  localparam int WideBits   = SlotBits + 2;
  localparam int AccBits    = 64;
  localparam int CntBits    = $clog2(MaxShifts + 1);
  localparam int RegBits    = 60;
  localparam int NrmIdxBits = 4;

  localparam logic [CntBits-1:0] CntMax = CntBits'(MaxShifts);
  localparam logic [CntBits-1:0] CntOne = CntBits'(1);

  localparam logic [1:0] RegLatA   = 2'd0;
  localparam logic [1:0] RegLatB   = 2'd1;
  localparam logic [1:0] RegLatC   = 2'd2;
  localparam logic [1:0] RegOrigin = 2'd3;

  // reset lattice is the unit cube, normals and far-face distances follow from it
  localparam logic [RegBits-1:0] LatAReset   = RegBits'(64'd1024);
  localparam logic [RegBits-1:0] LatBReset   = RegBits'(64'd1073741824);
  localparam logic [RegBits-1:0] LatCReset   = RegBits'(64'd1125899906842624);
  localparam logic [RegBits-1:0] OriginReset = '0;
  localparam logic signed [NormBits-1:0] UnitNorm = NormBits'(64'sd1048576);
  localparam logic signed [AccBits-1:0]  UnitDot  = AccBits'(64'sd1073741824);

  localparam logic signed [SlotBits-1:0] SatMax =
    SlotBits'((64'sd1 <<< (SatBits - 1)) - 64'sd1);
  localparam logic signed [SlotBits-1:0] SatMin =
    SlotBits'(-(64'sd1 <<< (SatBits - 1)));

  typedef struct packed {
    logic signed [CoordBits-1:0] pos_z;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_x;
  } req_t;

  typedef struct packed {
    logic                        shift_limit_hit;
    logic                        was_inside;
    logic signed [CoordBits-1:0] wrapped_z;
    logic signed [CoordBits-1:0] wrapped_y;
    logic signed [CoordBits-1:0] wrapped_x;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle, StNormMul, StNormWr, StNormDot, StNormFix, StNear, StDecide, StShift, StDone
  } state_e;

  function automatic logic signed [SlotBits-1:0] sat_fn(
    input logic signed [WideBits-1:0] v);
    logic signed [SlotBits-1:0] r;
    begin
      if (v > WideBits'(SatMax)) r = SatMax;
      else if (v < WideBits'(SatMin)) r = SatMin;
      else r = v[SlotBits-1:0];
      return r;
    end
  endfunction

  function automatic logic signed [NormBits-1:0] sx_norm(
    input logic signed [SlotBits-1:0] v);
    return NormBits'(v);
  endfunction

  function automatic logic signed [DiffBits-1:0] sx_diff(
    input logic signed [SlotBits-1:0] v);
    return DiffBits'(v);
  endfunction

  function automatic logic signed [WideBits-1:0] sx_wide(
    input logic signed [SlotBits-1:0] v);
    return WideBits'(v);
  endfunction

  function automatic logic signed [AccBits-1:0] mul_fn(
    input logic signed [NormBits-1:0] a, input logic signed [DiffBits-1:0] b);
    return AccBits'(a) * AccBits'(b);
  endfunction

endpackage

/* src/pcw_mac.sv */
// ----------------------------------------------------------------------------
// pcw_mac
// shared multiply accumulate unit, one product per cycle while enabled, registered
// ----------------------------------------------------------------------------
module pcw_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  clr_i,
  input  logic                                  en_i,
  input  logic signed [pcw_pkg::NormBits-1:0]   a_i,
  input  logic signed [pcw_pkg::DiffBits-1:0]   b_i,
  input  logic                                  sub_i,
  output logic signed [pcw_pkg::AccBits-1:0]    acc_o
);
  logic signed [pcw_pkg::AccBits-1:0] acc_q, acc_d, prod, base;

  assign prod = pcw_pkg::mul_fn(a_i, b_i);

  // clear with enable starts a fresh sum from the current product
  always_comb begin
    base  = clr_i ? '0 : acc_q;
    acc_d = base;
    if (en_i) acc_d = sub_i ? base - prod : base + prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule

/* src/periodic_cell_wrap.sv */
// ----------------------------------------------------------------------------
// periodic_cell_wrap
// wraps a Q10.10 position into a triclinic cell
// ----------------------------------------------------------------------------
// Each test of an axis is a three-term dot product on one shared multiply
// accumulator, one product per cycle, plus a decision state. A request
// first tests all three axes to find whether it lay inside, then tests each
// axis again, shifting by the lattice vector one component per cycle and
// testing the axis anew after every shift; at most 15 shifts are made per
// axis. A register write rebuilds the face normals on the same unit. Busy
// is high throughout; the result is shown for one cycle with done_o high
// and the receiver cannot stall it.
module periodic_cell_wrap (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pcw_pkg::req_t         req_i,
  output logic                  done_o,
  output pcw_pkg::rsp_t         rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [63:0]           cfg_data_i
);
  logic [pcw_pkg::RegBits-1:0]          reg_q [4];
  logic signed [pcw_pkg::NormBits-1:0]  nrm_q [9];
  logic signed [pcw_pkg::AccBits-1:0]   nl_q  [3];
  logic signed [pcw_pkg::SlotBits-1:0]  pos_q [3];
  pcw_pkg::state_e st_q, st_d;
  logic [1:0] ax_q, ax_d, term_q, term_d;
  logic sub_q, sub_d, scan_q, scan_d, inside_q, inside_d, hit_q, hit_d, dir_q, dir_d;
  logic [pcw_pkg::CntBits-1:0] cnt_q, cnt_d;

  logic pos_ld, pos_we, nrm_we, nrm_fix, cfg_we;
  logic mac_clr, mac_en, mac_sub;
  logic signed [pcw_pkg::NormBits-1:0] mac_a;
  logic signed [pcw_pkg::DiffBits-1:0] mac_b;
  logic signed [pcw_pkg::AccBits-1:0] acc, far_dist;
  logic [1:0] p_ax, q_ax, k1, k2;
  logic [pcw_pkg::NrmIdxBits-1:0] nidx;
  logic signed [pcw_pkg::SlotBits-1:0] lc;
  logic signed [pcw_pkg::WideBits-1:0] step;

  function automatic logic signed [pcw_pkg::SlotBits-1:0] comp(
    input logic [pcw_pkg::RegBits-1:0] r, input logic [1:0] k);
    logic signed [pcw_pkg::SlotBits-1:0] v;
    begin
      case (k)
        2'd0: v = r[pcw_pkg::SlotBits-1:0];
        2'd1: v = r[2*pcw_pkg::SlotBits-1:pcw_pkg::SlotBits];
        default: v = r[3*pcw_pkg::SlotBits-1:2*pcw_pkg::SlotBits];
      endcase
      return v;
    end
  endfunction

  function automatic logic [1:0] nxt(input logic [1:0] i);
    logic [1:0] r;
    begin
      r = (i == 2'd2) ? 2'd0 : i + 2'd1;
      return r;
    end
  endfunction

  pcw_mac u_mac (
    .clk_i, .rst_ni, .clr_i(mac_clr), .en_i(mac_en), .a_i(mac_a), .b_i(mac_b),
    .sub_i(mac_sub), .acc_o(acc)
  );

  assign busy        = (st_q != pcw_pkg::StIdle);
  assign cfg_ready_o = (st_q == pcw_pkg::StIdle) && !start;
  assign done_o      = (st_q == pcw_pkg::StDone);
  assign rsp_o       = '{shift_limit_hit: hit_q, was_inside: inside_q,
                         wrapped_z: pos_q[2], wrapped_y: pos_q[1], wrapped_x: pos_q[0]};

  always_comb begin
    st_d = st_q; ax_d = ax_q; term_d = term_q; sub_d = sub_q; cnt_d = cnt_q;
    scan_d = scan_q; inside_d = inside_q; hit_d = hit_q; dir_d = dir_q;
    pos_ld = 1'b0; pos_we = 1'b0; nrm_we = 1'b0; nrm_fix = 1'b0; cfg_we = 1'b0;
    mac_clr = 1'b0; mac_en = 1'b0; mac_sub = 1'b0; mac_a = '0; mac_b = '0;
    p_ax = nxt(ax_q); q_ax = nxt(p_ax);
    k1 = nxt(term_q); k2 = nxt(k1);
    nidx = 4'(ax_q) * 4'd3 + 4'(term_q);
    far_dist = acc - nl_q[ax_q];
    lc = comp(reg_q[ax_q], term_q);
    step = dir_q ? pcw_pkg::sx_wide(pos_q[term_q]) + pcw_pkg::sx_wide(lc)
                 : pcw_pkg::sx_wide(pos_q[term_q]) - pcw_pkg::sx_wide(lc);
    case (st_q)
      pcw_pkg::StIdle: begin
        if (start) begin
          pos_ld = 1'b1;
          st_d = pcw_pkg::StNear; ax_d = 2'd0; term_d = 2'd0; scan_d = 1'b1;
          inside_d = 1'b1; hit_d = 1'b0; cnt_d = '0;
        end else if (cfg_valid_i) begin
          cfg_we = 1'b1;
          st_d = pcw_pkg::StNormMul; ax_d = 2'd0; term_d = 2'd0; sub_d = 1'b0;
        end
      end
      // normal ax_q component term_q as a difference of two products
      pcw_pkg::StNormMul: begin
        mac_en  = 1'b1;
        mac_clr = !sub_q;
        mac_sub = sub_q;
        mac_a = pcw_pkg::sx_norm(comp(reg_q[p_ax], sub_q ? k2 : k1));
        mac_b = pcw_pkg::sx_diff(comp(reg_q[q_ax], sub_q ? k1 : k2));
        if (sub_q) st_d = pcw_pkg::StNormWr;
        sub_d = !sub_q;
      end
      pcw_pkg::StNormWr: begin
        nrm_we = 1'b1;
        if (term_q == 2'd2) begin
          term_d = 2'd0; st_d = pcw_pkg::StNormDot;
        end else begin
          term_d = term_q + 2'd1; st_d = pcw_pkg::StNormMul;
        end
      end
      pcw_pkg::StNormDot: begin
        mac_en  = 1'b1;
        mac_clr = (term_q == 2'd0);
        mac_a = nrm_q[nidx];
        mac_b = pcw_pkg::sx_diff(lc);
        if (term_q == 2'd2) begin
          term_d = 2'd0; st_d = pcw_pkg::StNormFix;
        end else begin
          term_d = term_q + 2'd1;
        end
      end
      pcw_pkg::StNormFix: begin
        nrm_fix = 1'b1;
        if (ax_q == 2'd2) begin
          ax_d = 2'd0; st_d = pcw_pkg::StIdle;
        end else begin
          ax_d = ax_q + 2'd1; sub_d = 1'b0; st_d = pcw_pkg::StNormMul;
        end
      end
      pcw_pkg::StNear: begin
        mac_en  = 1'b1;
        mac_clr = (term_q == 2'd0);
        mac_a = nrm_q[nidx];
        mac_b = pcw_pkg::sx_diff(pos_q[term_q])
              - pcw_pkg::sx_diff(comp(reg_q[pcw_pkg::RegOrigin], term_q));
        if (term_q == 2'd2) begin
          term_d = 2'd0; st_d = pcw_pkg::StDecide;
        end else begin
          term_d = term_q + 2'd1;
        end
      end
      pcw_pkg::StDecide: begin
        if (scan_q) begin
          if (acc[pcw_pkg::AccBits-1] || far_dist > 0) inside_d = 1'b0;
          if (ax_q == 2'd2) begin
            scan_d = 1'b0; ax_d = 2'd0;
          end else begin
            ax_d = ax_q + 2'd1;
          end
          st_d = pcw_pkg::StNear;
        end else if (!acc[pcw_pkg::AccBits-1] && !(far_dist > 0)) begin
          cnt_d = '0;
          if (ax_q == 2'd2) st_d = pcw_pkg::StDone;
          else begin
            ax_d = ax_q + 2'd1; st_d = pcw_pkg::StNear;
          end
        end else if (cnt_q == pcw_pkg::CntMax) begin
          hit_d = 1'b1;
          cnt_d = '0;
          if (ax_q == 2'd2) st_d = pcw_pkg::StDone;
          else begin
            ax_d = ax_q + 2'd1; st_d = pcw_pkg::StNear;
          end
        end else begin
          dir_d = acc[pcw_pkg::AccBits-1];
          term_d = 2'd0;
          st_d = pcw_pkg::StShift;
        end
      end
      pcw_pkg::StShift: begin
        pos_we = 1'b1;
        if (term_q == 2'd2) begin
          term_d = 2'd0; cnt_d = cnt_q + pcw_pkg::CntOne; st_d = pcw_pkg::StNear;
        end else begin
          term_d = term_q + 2'd1;
        end
      end
      pcw_pkg::StDone: begin
        st_d = pcw_pkg::StIdle;
      end
      default: begin
        st_d = pcw_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pcw_pkg::StIdle;
      ax_q <= '0; term_q <= '0; sub_q <= 1'b0; cnt_q <= '0;
      scan_q <= 1'b0; inside_q <= 1'b0; hit_q <= 1'b0; dir_q <= 1'b0;
      reg_q[pcw_pkg::RegLatA]   <= pcw_pkg::LatAReset;
      reg_q[pcw_pkg::RegLatB]   <= pcw_pkg::LatBReset;
      reg_q[pcw_pkg::RegLatC]   <= pcw_pkg::LatCReset;
      reg_q[pcw_pkg::RegOrigin] <= pcw_pkg::OriginReset;
      for (int k = 0; k < 9; k++) nrm_q[k] <= (k % 4 == 0) ? pcw_pkg::UnitNorm : '0;
      for (int k = 0; k < 3; k++) nl_q[k] <= pcw_pkg::UnitDot;
      for (int k = 0; k < 3; k++) pos_q[k] <= '0;
    end else begin
      st_q <= st_d;
      ax_q <= ax_d; term_q <= term_d; sub_q <= sub_d; cnt_q <= cnt_d;
      scan_q <= scan_d; inside_q <= inside_d; hit_q <= hit_d; dir_q <= dir_d;
      if (cfg_we) reg_q[cfg_index_i] <= cfg_data_i[pcw_pkg::RegBits-1:0];
      if (pos_ld) begin
        pos_q[0] <= req_i.pos_x;
        pos_q[1] <= req_i.pos_y;
        pos_q[2] <= req_i.pos_z;
      end else if (pos_we) begin
        pos_q[term_q] <= pcw_pkg::sat_fn(step);
      end
      if (nrm_we) begin
        nrm_q[nidx] <= acc[pcw_pkg::NormBits-1:0];
      end else if (nrm_fix) begin
        // flip the normal when it points away from its own lattice vector
        nl_q[ax_q] <= acc[pcw_pkg::AccBits-1] ? -acc : acc;
        if (acc[pcw_pkg::AccBits-1]) begin
          for (int k = 0; k < 3; k++) nrm_q[nidx + 4'(k)] <= -nrm_q[nidx + 4'(k)];
        end
      end
    end
  end
endmodule

/* verif/periodic_cell_wrap_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_cell_wrap_check
// watches the request, result and register channels of the cell wrap block,
// keeps its own copy of the lattice and face normals, predicts the wrapped
// position for every accepted request and compares each result with the
// oldest prediction
// ----------------------------------------------------------------------------
module periodic_cell_wrap_check (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           busy,
  input  pcw_pkg::req_t  req_i,
  input  logic           done_o,
  input  pcw_pkg::rsp_t  rsp_o,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [63:0]    cfg_data_i,
  output int             errors_o,
  output int             pending_o
);
  import pcw_pkg::*;

  logic [RegBits-1:0] cell_regs [4];
  longint lat [3][3];
  longint org [3];
  longint nrm [9];
  rsp_t   exp_mem [64];
  int     wr_ptr;
  int     rd_ptr;
  int     errors;

  function automatic longint slot_val(logic [RegBits-1:0] r, int k);
    logic signed [SlotBits-1:0] s;
    s = r[k*SlotBits +: SlotBits];
    return longint'(s);
  endfunction

  function automatic longint clamp(longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (SatBits - 1)) - 1;
    lo = -(64'sd1 <<< (SatBits - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void rebuild_normals();
    int p;
    int q;
    longint dp;
    for (int j = 0; j < 3; j++) begin
      lat[0][j] = slot_val(cell_regs[RegLatA], j);
      lat[1][j] = slot_val(cell_regs[RegLatB], j);
      lat[2][j] = slot_val(cell_regs[RegLatC], j);
      org[j]    = slot_val(cell_regs[RegOrigin], j);
    end
    for (int i = 0; i < 3; i++) begin
      p = (i + 1) % 3;
      q = (i + 2) % 3;
      nrm[i*3+0] = lat[p][1] * lat[q][2] - lat[p][2] * lat[q][1];
      nrm[i*3+1] = lat[p][2] * lat[q][0] - lat[p][0] * lat[q][2];
      nrm[i*3+2] = lat[p][0] * lat[q][1] - lat[p][1] * lat[q][0];
      dp = 0;
      for (int j = 0; j < 3; j++) dp += nrm[i*3+j] * lat[i][j];
      if (dp < 0)
        for (int j = 0; j < 3; j++) nrm[i*3+j] = -nrm[i*3+j];
    end
  endfunction

  // -1 behind origin face, +1 beyond far face, 0 inside
  function automatic int face_side(longint pos [3], int i);
    longint near_d;
    longint far_d;
    longint d;
    near_d = 0;
    far_d  = 0;
    for (int j = 0; j < 3; j++) begin
      d = pos[j] - org[j];
      near_d += nrm[i*3+j] * d;
      far_d  += nrm[i*3+j] * (d - lat[i][j]);
    end
    if (near_d < 0) return -1;
    if (far_d > 0) return 1;
    return 0;
  endfunction

  function automatic rsp_t wrap_position(req_t rq);
    longint pos [3];
    bit     was_in;
    bit     hit;
    int     cnt;
    int     s;
    rsp_t   r;
    pos[0] = longint'(rq.pos_x);
    pos[1] = longint'(rq.pos_y);
    pos[2] = longint'(rq.pos_z);
    was_in = 1'b1;
    hit    = 1'b0;
    for (int i = 0; i < 3; i++)
      if (face_side(pos, i) != 0) was_in = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cnt = 0;
      s = face_side(pos, i);
      while (s != 0) begin
        if (cnt >= MaxShifts) begin
          hit = 1'b1;
          break;
        end
        for (int j = 0; j < 3; j++)
          pos[j] = clamp(s < 0 ? pos[j] + lat[i][j] : pos[j] - lat[i][j]);
        cnt++;
        s = face_side(pos, i);
      end
    end
    r.wrapped_x       = CoordBits'(clamp(pos[0]));
    r.wrapped_y       = CoordBits'(clamp(pos[1]));
    r.wrapped_z       = CoordBits'(clamp(pos[2]));
    r.was_inside      = was_in;
    r.shift_limit_hit = hit;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      cell_regs[RegLatA]   = 60'd1024;
      cell_regs[RegLatB]   = 60'd1073741824;
      cell_regs[RegLatC]   = 60'd1125899906842624;
      cell_regs[RegOrigin] = '0;
      rebuild_normals();
      wr_ptr = 0;
      rd_ptr = 0;
      errors = 0;
    end else begin
      if (done_o) begin
        if (wr_ptr == rd_ptr) begin
          errors++;
          if (errors <= 10) $display("result with no request pending: %h", rsp_o);
        end else begin
          want = exp_mem[rd_ptr % 64];
          rd_ptr++;
          if (rsp_o !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected x %h y %h z %h in %b hit %b, got x %h y %h z %h in %b hit %b",
                       want.wrapped_x, want.wrapped_y, want.wrapped_z, want.was_inside,
                       want.shift_limit_hit, rsp_o.wrapped_x, rsp_o.wrapped_y,
                       rsp_o.wrapped_z, rsp_o.was_inside, rsp_o.shift_limit_hit);
          end
        end
      end
      if (start && !busy) begin
        exp_mem[wr_ptr % 64] = wrap_position(req_i);
        wr_ptr++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cell_regs[cfg_index_i] = cfg_data_i[RegBits-1:0];
        rebuild_normals();
      end
    end
  end

  initial begin
    cell_regs[RegLatA]   = 60'd1024;
    cell_regs[RegLatB]   = 60'd1073741824;
    cell_regs[RegLatC]   = 60'd1125899906842624;
    cell_regs[RegOrigin] = '0;
    wr_ptr = 0;
    rd_ptr = 0;
    errors = 0;
    rebuild_normals();
  end

  assign errors_o  = errors;
  assign pending_o = wr_ptr - rd_ptr;

endmodule

/* verif/periodic_cell_wrap_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_cell_wrap_test
// drives the cell wrap block through several lattice settings, from the unit
// cube to skewed, degenerate and extreme cells, with directed and random
// positions and random idle gaps; a checker beside the block predicts and
// compares every result
// ----------------------------------------------------------------------------
module periodic_cell_wrap_test;
  import pcw_pkg::*;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  req_t          req_i;
  logic          done_o;
  rsp_t          rsp_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i;
  logic [63:0]   cfg_data_i;
  int            errors;
  int            pending;
  int            cycles;
  int            idle_pct;
  int            sent;

  localparam int CycleLimit = 2000000;

  periodic_cell_wrap DUT (.*);

  periodic_cell_wrap_check checker_i (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [RegBits-1:0] vec3(int x, int y, int z);
    return {SlotBits'(z), SlotBits'(y), SlotBits'(x)};
  endfunction

  task automatic send_pos(int x, int y, int z);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{pos_z: CoordBits'(z), pos_y: CoordBits'(y), pos_x: CoordBits'(x)};
    #1;
    while (busy) begin
      @(negedge clk_i);
      #1;
    end
    sent++;
    if (sent == 150) idle_pct = 73;
    if (sent == 300) idle_pct = 0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [RegBits-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= {4'($urandom), val};
    #1;
    while (!cfg_ready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_cell(logic [RegBits-1:0] a, logic [RegBits-1:0] b,
                          logic [RegBits-1:0] c, logic [RegBits-1:0] o);
    drain();
    write_reg(RegLatA, a);
    write_reg(RegLatB, b);
    write_reg(RegLatC, c);
    write_reg(RegOrigin, o);
    while (busy) @(negedge clk_i);
  endtask

  function automatic int shear();
    return $urandom_range(512) - 256;
  endfunction

  function automatic int diag();
    int m;
    m = $urandom_range(3072, 256);
    return ($urandom_range(1) != 0) ? m : -m;
  endfunction

  task automatic random_positions(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 70)
        send_pos($urandom_range(12288) - 6144, $urandom_range(12288) - 6144,
                 $urandom_range(12288) - 6144);
      else if (k < 90)
        send_pos($urandom, $urandom, $urandom);
      else
        send_pos($urandom_range(1) ? 524287 : -524288, $urandom_range(2047) - 1024,
                 $urandom_range(1) ? -524288 : 524287);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    cycles      = 0;
    sent        = 0;
    idle_pct    = 20;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // unit cube after reset
    send_pos(0, 0, 0);
    send_pos(1024, 1024, 1024);
    send_pos(1025, 512, 0);
    send_pos(-1, 512, 512);
    send_pos(524287, 524287, 524287);
    send_pos(-524288, -524288, -524288);
    send_pos(524287, -524288, 0);
    send_pos(-16384, 16384, 15360);
    send_pos(15360, 15361, -14336);
    send_pos(300, 700, 1023);
    random_positions(50);

    set_cell(vec3(diag(), shear(), shear()), vec3(shear(), diag(), shear()),
             vec3(shear(), shear(), diag()),
             vec3($urandom_range(4096) - 2048, $urandom_range(4096) - 2048,
                  $urandom_range(4096) - 2048));
    send_pos(0, 0, 0);
    random_positions(60);

    // arbitrary register contents
    set_cell({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom});
    random_positions(30);

    // degenerate: zero third vector, then zero first and second too
    set_cell(vec3(2048, 0, 0), vec3(300, 1536, 0), '0, vec3(-100, 50, 0));
    send_pos(0, 0, 0);
    send_pos(524287, 524287, 524287);
    random_positions(30);
    set_cell('0, '0, '0, '0);
    send_pos(5, -5, 7);
    random_positions(10);

    // extreme components
    set_cell(vec3(524287, 0, 0), vec3(0, 524287, 0), vec3(0, 0, 524287),
             vec3(-524288, -524288, -524288));
    send_pos(-524288, -524288, -524288);
    send_pos(524287, 524287, 524287);
    random_positions(30);
    set_cell(vec3(-524288, -524288, -524288), vec3(524287, -524288, 524287),
             vec3(-524288, 524287, 524287), vec3(524287, 524287, 524287));
    random_positions(20);

    // skewed cells with the large components of the first two vectors swapped
    for (int ph = 0; ph < 4; ph++) begin
      set_cell(vec3(shear(), diag(), shear()), vec3(diag(), shear(), shear()),
               vec3(shear(), shear(), diag()),
               vec3($urandom_range(2048) - 1024, $urandom_range(2048) - 1024,
                    $urandom_range(2048) - 1024));
      random_positions(50);
    end

    set_cell(60'd1024, 60'd1073741824, 60'd1125899906842624, '0);
    random_positions(10);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
